### rtl/tom_pkg.sv
// ----------------------------------------------------------------------------
// tom_pkg
// Shared types and constants for the thermal over-temperature monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package tom_pkg;

    localparam int TEMP_W       = 9;
    localparam int SENSOR_IDX_W = 2;
    localparam int FAN_W        = 16;
    localparam int TIMER_W      = 17;
    localparam int COUNT_OUT_W  = 3;
    localparam int NUM_THR      = 4;
    localparam int DROP_W       = 8;
    localparam int PERIOD_W     = 16;
    localparam int APB_ADDR_W   = 5;
    localparam int APB_DATA_W   = 32;

    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    typedef enum logic [2:0] {
        REG_THR0       = 3'd0,
        REG_THR1       = 3'd1,
        REG_THR2       = 3'd2,
        REG_THR3       = 3'd3,
        REG_HYST_DROP  = 3'd4,
        REG_CRIT_RISE  = 3'd5,
        REG_PERIOD     = 3'd6,
        REG_SHUT_DELAY = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        FAN_NONE    = 2'd0,
        FAN_MAX     = 2'd1,
        FAN_RESTORE = 2'd2
    } fan_cmd_t;

    typedef struct packed {
        logic [NUM_THR-1:0][TEMP_W-1:0] threshold;
        logic [DROP_W-1:0]              hyst_drop;
        logic [DROP_W-1:0]              crit_rise;
        logic [PERIOD_W-1:0]            period;
        logic [PERIOD_W-1:0]            shut_delay;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        threshold:  {9'd80, 9'd65, 9'd80, 9'd70},
        hyst_drop:  8'd5,
        crit_rise:  8'd5,
        period:     16'd999,
        shut_delay: 16'd10000
    };

endpackage

`default_nettype wire

### rtl/tom_sample_if.sv
// ----------------------------------------------------------------------------
// tom_sample_if
// Sample channel: one temperature reading per word, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tom_sample_if import tom_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [SENSOR_IDX_W-1:0]  sensor_index;
    logic                     sample_ok;
    logic signed [TEMP_W-1:0] temperature_c;
    logic [FAN_W-1:0]         fan_speed_now;

    modport source (
        output valid, sensor_index, sample_ok, temperature_c, fan_speed_now,
        input  ready
    );

    modport sink (
        input  valid, sensor_index, sample_ok, temperature_c, fan_speed_now,
        output ready
    );

endinterface

`default_nettype wire

### rtl/tom_result_if.sv
// ----------------------------------------------------------------------------
// tom_result_if
// Result channel: one status word per sample word, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tom_result_if import tom_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic                     report_valid;
    logic [SENSOR_IDX_W-1:0]  report_sensor;
    logic signed [TEMP_W-1:0] average_c;
    logic [COUNT_OUT_W-1:0]   overtemp_count;
    logic                     any_overtemp;
    logic [1:0]               fan_command;
    logic [FAN_W-1:0]         fan_value;
    logic                     shutdown;

    modport source (
        output valid, report_valid, report_sensor, average_c, overtemp_count,
               any_overtemp, fan_command, fan_value, shutdown,
        input  ready
    );

    modport sink (
        input  valid, report_valid, report_sensor, average_c, overtemp_count,
               any_overtemp, fan_command, fan_value, shutdown,
        output ready
    );

endinterface

`default_nettype wire

### rtl/tom_cfg_regs.sv
// ----------------------------------------------------------------------------
// tom_cfg_regs
// APB register file holding thresholds, hysteresis and timer settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tom_cfg_regs import tom_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t idx;
    logic       wr_en;

    assign idx    = reg_index_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_THR0, REG_THR1, REG_THR2, REG_THR3:
                    cfg_next.threshold[paddr[3:2]] = pwdata[TEMP_W-1:0];
                REG_HYST_DROP:  cfg_next.hyst_drop  = pwdata[DROP_W-1:0];
                REG_CRIT_RISE:  cfg_next.crit_rise  = pwdata[DROP_W-1:0];
                REG_PERIOD:     cfg_next.period     = pwdata[PERIOD_W-1:0];
                REG_SHUT_DELAY: cfg_next.shut_delay = pwdata[PERIOD_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_THR0, REG_THR1, REG_THR2, REG_THR3:
                prdata = {{(APB_DATA_W-TEMP_W){cfg_reg.threshold[paddr[3:2]][TEMP_W-1]}},
                          cfg_reg.threshold[paddr[3:2]]};
            REG_HYST_DROP:  prdata = APB_DATA_W'(cfg_reg.hyst_drop);
            REG_CRIT_RISE:  prdata = APB_DATA_W'(cfg_reg.crit_rise);
            REG_PERIOD:     prdata = APB_DATA_W'(cfg_reg.period);
            REG_SHUT_DELAY: prdata = APB_DATA_W'(cfg_reg.shut_delay);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### rtl/tom_round_div.sv
// ----------------------------------------------------------------------------
// tom_round_div
// Rounded division of a history sum by the history depth, one register deep.
// ----------------------------------------------------------------------------
`default_nettype none

module tom_round_div import tom_pkg::*; #(
    parameter  int AVERAGE_DEPTH = 3,
    localparam int SUM_W         = TEMP_W + $clog2(AVERAGE_DEPTH)
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [SUM_W-1:0] sum,
    output logic signed [TEMP_W:0]  avg
);

    // Rounded |sum| / D is floor((2|sum| + D) / 2D). The numerator stays below
    // 2^NUM_W, so a reciprocal with SHIFT = NUM_W + 5 fractional bits gives
    // the exact floor for every divisor up to 16.
    localparam int NUM_W  = SUM_W + 1;
    localparam int DIV    = 2 * AVERAGE_DEPTH;
    localparam int SHIFT  = NUM_W + 5;
    localparam int RECIP  = ((1 << SHIFT) + DIV - 1) / DIV;
    localparam int PROD_W = NUM_W + SHIFT;

    logic [SUM_W-1:0]        mag;
    logic [NUM_W-1:0]        num;
    logic [PROD_W-1:0]       prod;
    logic signed [TEMP_W:0]  quo;
    logic signed [TEMP_W:0]  avg_next;
    logic signed [TEMP_W:0]  avg_reg;

    always_comb
    begin
        mag      = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        num      = {mag, 1'b0} + NUM_W'(AVERAGE_DEPTH);
        prod     = PROD_W'(num) * PROD_W'(RECIP);
        quo      = {1'b0, prod[SHIFT +: TEMP_W]};
        avg_next = sum[SUM_W-1] ? -quo : quo;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            avg_reg <= avg_next;
        end
    end

    assign avg = avg_reg;

endmodule

`default_nettype wire

### rtl/thermal_overtemp_monitor_core.sv
// ----------------------------------------------------------------------------
// thermal_overtemp_monitor_core: averaged per-sensor over-temperature monitor.
// Each accepted sample word yields one result word from the output register.
// Throughput: one word per cycle; a sample word is refused only while a result
// word waits on the report channel. Reset clears valid flags, counts and config at once.
// ----------------------------------------------------------------------------
`default_nettype none

module thermal_overtemp_monitor_core import tom_pkg::*; #(
    parameter int SENSOR_COUNT  = 4,
    parameter int AVERAGE_DEPTH = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    tom_sample_if.sink            sample,
    tom_result_if.source          report
);

    localparam int ADDR_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int POS_W  = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
    localparam int HIST_W = AVERAGE_DEPTH * TEMP_W;
    localparam int ROWA_W = HIST_W + POS_W;
    localparam int ROWB_W = TIMER_W + 1;
    localparam int SUM_W  = TEMP_W + $clog2(AVERAGE_DEPTH);
    localparam int CNT_W  = $clog2(SENSOR_COUNT + 1);
    localparam int CMP_W  = TEMP_W + 2;

    cfg_t cfg;

    tom_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------------
    // Flow control: the whole pipeline holds while a result word waits.
    // ------------------------------------------------------------------------
    logic adv;
    logic accept;
    logic out_valid_reg;

    assign adv          = !(out_valid_reg && !report.ready);
    assign sample.ready = adv;
    assign accept       = sample.valid && adv;

    logic [ADDR_W-1:0] in_addr;
    logic              in_range;

    assign in_addr  = ADDR_W'(sample.sensor_index);
    assign in_range = {4'b0, sample.sensor_index} < 6'(SENSOR_COUNT);

    // ------------------------------------------------------------------------
    // Stage 1: history row read-modify-write.
    // ------------------------------------------------------------------------
    logic                     s1_valid_reg;
    logic [SENSOR_IDX_W-1:0]  s1_sensor_reg;
    logic                     s1_ok_reg;
    logic signed [TEMP_W-1:0] s1_temp_reg;
    logic [FAN_W-1:0]         s1_fan_reg;
    logic                     s1_in_range_reg;
    logic [ADDR_W-1:0]        s1_addr;

    logic [ROWA_W-1:0]        mem_a [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0]  a_row_valid_reg;
    logic [ROWA_W-1:0]        a_rdata_reg;
    logic                     a_vld_q_reg;
    logic                     a_fwd_reg;
    logic [ROWA_W-1:0]        a_fwd_data_reg;
    logic                     a_we;
    logic [ROWA_W-1:0]        a_wdata;

    logic [ROWA_W-1:0]        row_a;
    logic signed [TEMP_W-1:0] hist_cur [AVERAGE_DEPTH];
    logic signed [TEMP_W-1:0] hist_new [AVERAGE_DEPTH];
    logic [POS_W-1:0]         pos_cur;
    logic [POS_W-1:0]         pos_next;
    logic signed [SUM_W-1:0]  sum_next;
    logic                     s1_report;

    assign s1_addr = ADDR_W'(s1_sensor_reg);
    assign a_we    = adv && s1_valid_reg && s1_in_range_reg;

    always_comb
    begin
        row_a = a_fwd_reg ? a_fwd_data_reg : (a_vld_q_reg ? a_rdata_reg : '0);
        pos_cur = row_a[HIST_W +: POS_W];
        pos_next = (pos_cur == POS_W'(AVERAGE_DEPTH - 1)) ? '0 : pos_cur + 1'b1;
        sum_next = '0;
        a_wdata = '0;
        for (int k = 0; k < AVERAGE_DEPTH; k++)
        begin
            hist_cur[k] = row_a[k*TEMP_W +: TEMP_W];
            hist_new[k] = (s1_ok_reg && pos_cur == POS_W'(k)) ? s1_temp_reg : hist_cur[k];
            sum_next = sum_next + SUM_W'(hist_new[k]);
            a_wdata[k*TEMP_W +: TEMP_W] = hist_new[k];
        end
        a_wdata[HIST_W +: POS_W] = pos_next;
        s1_report = s1_ok_reg && s1_in_range_reg && (pos_next == '0);
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            mem_a[s1_addr] <= a_wdata;
        end
        if (accept)
        begin
            a_rdata_reg <= mem_a[in_addr];
        end
    end

    // A row written by the item in stage 1 on the same edge bypasses the memory.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_vld_q_reg    <= a_row_valid_reg[in_addr];
            a_fwd_reg      <= a_we && (s1_addr == in_addr);
            a_fwd_data_reg <= a_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_row_valid_reg <= '0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            if (a_we)
            begin
                a_row_valid_reg[s1_addr] <= 1'b1;
            end
            if (adv)
            begin
                s1_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sensor_reg   <= sample.sensor_index;
            s1_ok_reg       <= sample.sample_ok;
            s1_temp_reg     <= sample.temperature_c;
            s1_fan_reg      <= sample.fan_speed_now;
            s1_in_range_reg <= in_range;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: rounded average.
    // ------------------------------------------------------------------------
    logic                    s2_valid_reg;
    logic [SENSOR_IDX_W-1:0] s2_sensor_reg;
    logic                    s2_report_reg;
    logic [FAN_W-1:0]        s2_fan_reg;
    logic signed [SUM_W-1:0] s2_sum_reg;
    logic signed [TEMP_W:0]  s3_avg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_sensor_reg <= s1_sensor_reg;
            s2_report_reg <= s1_report;
            s2_fan_reg    <= s1_fan_reg;
            s2_sum_reg    <= sum_next;
        end
    end

    tom_round_div #(
        .AVERAGE_DEPTH (AVERAGE_DEPTH)
    ) u_div (
        .clk (clk),
        .en  (adv),
        .sum (s2_sum_reg),
        .avg (s3_avg)
    );

    // ------------------------------------------------------------------------
    // Stage 3: flag and timer read-modify-write, shared count and fan state.
    // ------------------------------------------------------------------------
    logic                    s3_valid_reg;
    logic [SENSOR_IDX_W-1:0] s3_sensor_reg;
    logic                    s3_report_reg;
    logic [FAN_W-1:0]        s3_fan_reg;
    logic [ADDR_W-1:0]       s2_addr;
    logic [ADDR_W-1:0]       s3_addr;

    logic [ROWB_W-1:0]       mem_b [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] b_row_valid_reg;
    logic [ROWB_W-1:0]       b_rdata_reg;
    logic                    b_vld_q_reg;
    logic                    b_fwd_reg;
    logic [ROWB_W-1:0]       b_fwd_data_reg;
    logic                    b_we;
    logic [ROWB_W-1:0]       b_wdata;

    logic [ROWB_W-1:0]       row_b;
    logic                    flag_cur;
    logic [TIMER_W-1:0]      time_cur;
    logic [TIMER_W:0]        time_sum;
    logic [TIMER_W-1:0]      time_new;
    logic signed [TEMP_W-1:0] thr;
    logic signed [CMP_W-1:0] thr_ext;
    logic signed [CMP_W-1:0] avg_ext;
    logic signed [CMP_W-1:0] hot_lim;
    logic signed [CMP_W-1:0] cool_lim;
    logic                    critical;
    logic                    set_flag;
    logic                    clr_flag;
    logic                    flag_new;
    logic                    shut;
    logic                    upd;

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CNT_W-1:0]        count_dec;
    logic [FAN_W-1:0]        saved_fan_reg;
    logic [FAN_W-1:0]        saved_fan_next;
    fan_cmd_t                fan_next;
    logic [FAN_W-1:0]        fan_val_next;

    assign s2_addr = ADDR_W'(s2_sensor_reg);
    assign s3_addr = ADDR_W'(s3_sensor_reg);
    assign upd     = adv && s3_valid_reg && s3_report_reg;
    assign b_we    = upd;

    always_comb
    begin
        row_b    = b_fwd_reg ? b_fwd_data_reg : (b_vld_q_reg ? b_rdata_reg : '0);
        flag_cur = row_b[TIMER_W];
        time_cur = row_b[TIMER_W-1:0];

        thr      = cfg.threshold[s3_sensor_reg];
        thr_ext  = CMP_W'(thr);
        avg_ext  = CMP_W'(s3_avg);
        hot_lim  = thr_ext + signed'(CMP_W'(cfg.crit_rise));
        cool_lim = thr_ext - signed'(CMP_W'(cfg.hyst_drop));

        critical = avg_ext > hot_lim;
        time_sum = {1'b0, time_cur} + (TIMER_W + 1)'(cfg.period);
        if (!critical)
        begin
            time_new = '0;
        end
        else if (time_sum[TIMER_W])
        begin
            time_new = TIMER_MAX;
        end
        else
        begin
            time_new = time_sum[TIMER_W-1:0];
        end
        shut = critical && (time_new > TIMER_W'(cfg.shut_delay));

        set_flag = !flag_cur && (avg_ext > thr_ext);
        clr_flag = flag_cur && (avg_ext < cool_lim);
        flag_new = set_flag ? 1'b1 : (clr_flag ? 1'b0 : flag_cur);
        b_wdata  = {flag_new, time_new};

        count_dec      = (count_reg != '0) ? count_reg - 1'b1 : count_reg;
        count_next     = count_reg;
        saved_fan_next = saved_fan_reg;
        fan_next       = FAN_NONE;
        fan_val_next   = '0;
        if (s3_report_reg)
        begin
            if (set_flag)
            begin
                count_next = count_reg + 1'b1;
                if (count_reg == '0)
                begin
                    saved_fan_next = s3_fan_reg;
                    fan_next       = FAN_MAX;
                end
            end
            else if (clr_flag)
            begin
                count_next = count_dec;
                if (count_dec == '0)
                begin
                    fan_next     = FAN_RESTORE;
                    fan_val_next = saved_fan_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            mem_b[s3_addr] <= b_wdata;
        end
        if (adv)
        begin
            b_rdata_reg <= mem_b[s2_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_vld_q_reg    <= b_row_valid_reg[s2_addr];
            b_fwd_reg      <= b_we && (s3_addr == s2_addr);
            b_fwd_data_reg <= b_wdata;
            s3_sensor_reg  <= s2_sensor_reg;
            s3_report_reg  <= s2_report_reg;
            s3_fan_reg     <= s2_fan_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------------
    logic                     out_report_reg;
    logic [SENSOR_IDX_W-1:0]  out_sensor_reg;
    logic signed [TEMP_W-1:0] out_avg_reg;
    logic [COUNT_OUT_W-1:0]   out_cnt_reg;
    logic                     out_any_reg;
    fan_cmd_t                 out_fan_reg;
    logic [FAN_W-1:0]         out_fan_val_reg;
    logic                     out_shut_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            b_row_valid_reg <= '0;
            count_reg       <= '0;
            saved_fan_reg   <= '0;
        end
        else
        begin
            if (adv)
            begin
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                out_valid_reg <= s3_valid_reg;
            end
            if (upd)
            begin
                b_row_valid_reg[s3_addr] <= 1'b1;
                count_reg                <= count_next;
                saved_fan_reg            <= saved_fan_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_report_reg  <= s3_report_reg;
            out_sensor_reg  <= s3_sensor_reg;
            out_avg_reg     <= s3_report_reg ? s3_avg[TEMP_W-1:0] : '0;
            out_cnt_reg     <= COUNT_OUT_W'(count_next);
            out_any_reg     <= (count_next != '0);
            out_fan_reg     <= fan_next;
            out_fan_val_reg <= fan_val_next;
            out_shut_reg    <= s3_report_reg && shut;
        end
    end

    assign report.valid          = out_valid_reg;
    assign report.report_valid   = out_report_reg;
    assign report.report_sensor  = out_sensor_reg;
    assign report.average_c      = out_avg_reg;
    assign report.overtemp_count = out_cnt_reg;
    assign report.any_overtemp   = out_any_reg;
    assign report.fan_command    = out_fan_reg;
    assign report.fan_value      = out_fan_val_reg;
    assign report.shutdown       = out_shut_reg;

`ifndef SYNTHESIS
    a_quiet_without_report: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_report_reg) |->
            (out_fan_reg == FAN_NONE && !out_shut_reg && out_avg_reg == '0))
        else $error("result word without a report carries fan, shutdown or average");

    a_fan_max_on_first: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_fan_reg == FAN_MAX) |-> (out_cnt_reg == 'd1))
        else $error("fan maximum commanded while count is not one");

    a_restore_when_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_fan_reg == FAN_RESTORE) |->
            (out_cnt_reg == '0 && !out_any_reg))
        else $error("fan restore commanded while sensors are still over temperature");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SENSOR_COUNT))
        else $error("over-temperature count exceeds sensor count");
`endif

endmodule

`default_nettype wire
